// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RRDL_ASSERT_IMPL(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RRDL_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rrdl_pkg.sv
package rrdl_pkg;

    // Ladder size and level resolution
    localparam int NUM_SUPPLIES = 5;
    localparam int DUTY_BITS    = 9;

    // Fixed field widths
    localparam int FUNC_W     = 3;
    localparam int STEP_W     = 12;
    localparam int VOLT_W     = 14;
    localparam int DUTY_OUT_W = 9;
    localparam int DUTY_OUTS  = 5;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // Derived widths
    localparam int PTR_W = $clog2(NUM_SUPPLIES);
    localparam int Q_W   = $clog2((2 ** STEP_W - 1) / NUM_SUPPLIES + 2);
    localparam int SUM_W = ((DUTY_BITS > Q_W) ? DUTY_BITS : Q_W) + 1;

    // Reciprocal for step_count / NUM_SUPPLIES (exact for all 12-bit counts)
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = STEP_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((2 ** DIV_SHIFT + NUM_SUPPLIES - 1) / NUM_SUPPLIES);

    // Level constants
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = '1;
    localparam logic [DUTY_BITS-1:0] DUTY_MIN  = DUTY_BITS'(DUTY_FULL - 1'b1);
    localparam logic [DUTY_BITS-1:0] DUTY_MID  = DUTY_FULL >> 1;

    // Voltage limit reset value
    localparam logic [VOLT_W-1:0] LIMIT_RESET = VOLT_W'(5840);

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INC      = 3'd0,
        FUNC_DEC      = 3'd1,
        FUNC_SET_MIN  = 3'd2,
        FUNC_BOTTOM   = 3'd3,
        FUNC_MID      = 3'd4,
        FUNC_TOP      = 3'd5,
        FUNC_BOOST_ON = 3'd6,
        FUNC_BOOST_OFF = 3'd7
    } func_t;

    // Per-lane update operations
    typedef enum logic [1:0] {
        LANE_HOLD = 2'd0,
        LANE_SUB  = 2'd1,
        LANE_ADD  = 2'd2,
        LANE_FILL = 2'd3
    } lane_op_t;

    typedef struct packed {
        lane_op_t               op;
        logic [Q_W-1:0]         amount;
        logic [DUTY_BITS-1:0]   fill;
    } lane_ctl_t;

endpackage

// File: sv/rrdl_lane.sv
// One duty level with its saturating update.
module rrdl_lane
    import rrdl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctl_t            ctl,
    output logic [DUTY_BITS-1:0] level,
    output logic [DUTY_BITS-1:0] level_next
);

    logic [DUTY_BITS-1:0] level_reg;
    logic [SUM_W-1:0]     ext_lev;
    logic [SUM_W-1:0]     ext_amt;
    logic [SUM_W-1:0]     sum;

    assign ext_lev = SUM_W'(level_reg);
    assign ext_amt = SUM_W'(ctl.amount);
    assign sum     = ext_lev + ext_amt;

    // Next level: subtract to zero, add to full scale, load, or hold
    always_comb
    begin
        case (ctl.op)
            LANE_SUB:
            begin
                level_next = (ext_lev > ext_amt) ? DUTY_BITS'(ext_lev - ext_amt) : '0;
            end
            LANE_ADD:
            begin
                level_next = (sum >= SUM_W'(DUTY_FULL)) ? DUTY_FULL : DUTY_BITS'(sum);
            end
            LANE_FILL:
            begin
                level_next = ctl.fill;
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= DUTY_FULL;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

// File: sv/round_robin_duty_ladder_unit.sv
// Round-robin duty ladder.
// Keeps NUM_SUPPLIES PWM duty levels (higher duty = less power), a rotating
// step pointer and a boost flag. Commands arrive on the s_* stream (one
// command per transaction); each command yields exactly one result on the
// m_* stream carrying all reported levels and the summary flags.
// cfg_we/cfg_wdata write the battery voltage limit that blocks increases;
// write it only while no command is in flight.
// An accepted command is registered in the input stage, then its result in
// the result register that drives m_tvalid and m_tdata. Throughput: one
// command per cycle while m_tready is high. The step_count split into
// per-supply shares is a constant-reciprocal multiply in the input stage;
// the saturating update of every level is done in parallel in the second
// stage, which also writes the ladder state.
// Reset (rst_n low, asynchronous) sets every level to full scale, the pointer
// and boost flag to zero, the voltage limit to 5840 and empties both stages.
// When the receiver holds m_tready low the result register holds its
// transaction, the input stage holds the next command, and s_tready drops
// once both are occupied.
module round_robin_duty_ladder_unit
    import rrdl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // step_count[11:0], battery_voltage[25:12]
    input  logic [FUNC_W-1:0]    s_tuser,   // func[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // duty_0..duty_4[44:0], all_at_full[45],
                                            // all_at_zero[46], boost_on[47]
    input  logic                 cfg_we,
    input  logic [VOLT_W-1:0]    cfg_wdata
);

`include "assert_macros.svh"

    // Modular helpers for pointer arithmetic (operands below NUM_SUPPLIES)
    function automatic logic [PTR_W-1:0] add_mod(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        begin
            s = (PTR_W+1)'(a) + (PTR_W+1)'(b);
            if (s >= (PTR_W+1)'(NUM_SUPPLIES))
                s = s - (PTR_W+1)'(NUM_SUPPLIES);
            return PTR_W'(s);
        end
    endfunction

    function automatic logic [PTR_W-1:0] sub_mod(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        logic [PTR_W:0] d;
        begin
            if (a >= b)
                d = (PTR_W+1)'(a) - (PTR_W+1)'(b);
            else
                d = (PTR_W+1)'(a) + (PTR_W+1)'(NUM_SUPPLIES) - (PTR_W+1)'(b);
            return PTR_W'(d);
        end
    endfunction

    // Input field unpacking
    logic [STEP_W-1:0] in_steps;
    logic [VOLT_W-1:0] in_volts;
    assign in_steps = s_tdata[STEP_W-1:0];
    assign in_volts = s_tdata[STEP_W +: VOLT_W];

    // Control registers
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic [VOLT_W-1:0] limit_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic              boost_reg;
    logic              boost_next;

    // Input stage payload
    func_t             func_reg;
    logic [Q_W-1:0]    q_reg;
    logic [PTR_W-1:0]  r_reg;
    logic              blocked_reg;

    // Output stage payload
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    logic s_fire;
    logic adv;

    // Handshake: stage 2 advances when the result register is free or draining
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    // Split step_count into quotient and remainder by NUM_SUPPLIES
    logic [PROD_W-1:0] div_prod;
    logic [Q_W-1:0]    div_q;
    logic [STEP_W-1:0] div_qn;
    logic [PTR_W-1:0]  div_r;

    assign div_prod = PROD_W'(in_steps) * PROD_W'(DIV_RECIP);
    assign div_q    = div_prod[DIV_SHIFT +: Q_W];
    assign div_qn   = STEP_W'(div_q * STEP_W'(NUM_SUPPLIES));
    assign div_r    = PTR_W'(in_steps - div_qn);

    // Voltage limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (adv)
            in_valid_reg <= 1'b0;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            func_reg    <= func_t'(s_tuser);
            q_reg       <= div_q;
            r_reg       <= div_r;
            blocked_reg <= (in_volts >= limit_reg);
        end
    end

    // Ladder lanes
    lane_ctl_t            lane_ctl   [NUM_SUPPLIES];
    logic [DUTY_BITS-1:0] level      [NUM_SUPPLIES];
    logic [DUTY_BITS-1:0] level_next [NUM_SUPPLIES];

    for (genvar g = 0; g < NUM_SUPPLIES; g++)
    begin : g_lane
        rrdl_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl[g]),
            .level      (level[g]),
            .level_next (level_next[g])
        );
    end

    // Summary of current levels: every level at full scale
    logic at_min;
    always_comb
    begin
        at_min = 1'b1;
        for (int i = 0; i < NUM_SUPPLIES; i++)
            if (level[i] != DUTY_FULL)
                at_min = 1'b0;
    end

    // Per-supply step shares for increase (forward) and decrease (backward)
    logic [Q_W-1:0] share_inc [NUM_SUPPLIES];
    logic [Q_W-1:0] share_dec [NUM_SUPPLIES];
    always_comb
    begin
        logic [PTR_W-1:0] k_inc;
        logic [PTR_W-1:0] back;
        logic [PTR_W-1:0] k_dec;
        for (int i = 0; i < NUM_SUPPLIES; i++)
        begin
            k_inc = sub_mod(PTR_W'(i), ptr_reg);
            back  = sub_mod(ptr_reg, PTR_W'(i));
            k_dec = (back == '0) ? PTR_W'(NUM_SUPPLIES - 1) : PTR_W'(back - 1'b1);
            share_inc[i] = q_reg + Q_W'(k_inc < r_reg);
            share_dec[i] = q_reg + Q_W'(k_dec < r_reg);
        end
    end

    // Command decode: lane operations, pointer and boost flag
    always_comb
    begin
        ptr_next   = ptr_reg;
        boost_next = boost_reg;
        for (int i = 0; i < NUM_SUPPLIES; i++)
        begin
            lane_ctl[i].op     = LANE_HOLD;
            lane_ctl[i].amount = share_inc[i];
            lane_ctl[i].fill   = DUTY_FULL;
        end
        if (adv)
        begin
            case (func_reg)
                FUNC_INC:
                begin
                    if (!blocked_reg)
                    begin
                        for (int i = 0; i < NUM_SUPPLIES; i++)
                            lane_ctl[i].op = LANE_SUB;
                        ptr_next = add_mod(ptr_reg, r_reg);
                    end
                end
                FUNC_DEC:
                begin
                    // skipped at minimum power unless boost is on, which it clears
                    if (!at_min || boost_reg)
                    begin
                        if (at_min)
                            boost_next = 1'b0;
                        for (int i = 0; i < NUM_SUPPLIES; i++)
                        begin
                            lane_ctl[i].op     = LANE_ADD;
                            lane_ctl[i].amount = share_dec[i];
                        end
                        ptr_next = sub_mod(ptr_reg, r_reg);
                    end
                end
                FUNC_SET_MIN:
                begin
                    for (int i = 0; i < NUM_SUPPLIES; i++)
                    begin
                        lane_ctl[i].op   = LANE_FILL;
                        lane_ctl[i].fill = DUTY_MIN;
                    end
                    ptr_next = '0;
                end
                FUNC_BOTTOM:
                begin
                    for (int i = 0; i < NUM_SUPPLIES; i++)
                    begin
                        lane_ctl[i].op   = LANE_FILL;
                        lane_ctl[i].fill = '0;
                    end
                end
                FUNC_MID:
                begin
                    for (int i = 0; i < NUM_SUPPLIES; i++)
                    begin
                        lane_ctl[i].op   = LANE_FILL;
                        lane_ctl[i].fill = DUTY_MID;
                    end
                end
                FUNC_TOP:
                begin
                    for (int i = 0; i < NUM_SUPPLIES; i++)
                    begin
                        lane_ctl[i].op   = LANE_FILL;
                        lane_ctl[i].fill = DUTY_FULL;
                    end
                end
                FUNC_BOOST_ON:
                begin
                    boost_next = 1'b1;
                end
                FUNC_BOOST_OFF:
                begin
                    boost_next = 1'b0;
                end
                default:
                begin
                    boost_next = boost_reg;
                end
            endcase
        end
    end

    // Pointer and boost flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            boost_reg <= 1'b0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            boost_reg <= boost_next;
        end
    end

    // Reported levels: missing supplies read zero
    logic [DUTY_OUT_W-1:0] duty_out [DUTY_OUTS];
    for (genvar j = 0; j < DUTY_OUTS; j++)
    begin : g_out
        if (j < NUM_SUPPLIES)
        begin : g_used
            assign duty_out[j] = DUTY_OUT_W'(level_next[j]);
        end
        else
        begin : g_unused
            assign duty_out[j] = '0;
        end
    end

    // Result assembly from the updated levels
    always_comb
    begin
        logic all_full;
        logic all_zero;
        all_full = 1'b1;
        all_zero = 1'b1;
        for (int i = 0; i < NUM_SUPPLIES; i++)
        begin
            if (level_next[i] != DUTY_FULL)
                all_full = 1'b0;
            if (level_next[i] != '0)
                all_zero = 1'b0;
        end
        m_data_next = '0;
        for (int j = 0; j < DUTY_OUTS; j++)
            m_data_next[j*DUTY_OUT_W +: DUTY_OUT_W] = duty_out[j];
        m_data_next[DUTY_OUTS*DUTY_OUT_W]     = all_full;
        m_data_next[DUTY_OUTS*DUTY_OUT_W + 1] = all_zero;
        m_data_next[DUTY_OUTS*DUTY_OUT_W + 2] = boost_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            m_data_reg <= m_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    `RRDL_ASSERT_IMPL(a_ptr_range, 1'b1, (int'(ptr_reg) < NUM_SUPPLIES),
        "step pointer out of range")
    `RRDL_ASSERT_NEXT(a_state_hold, !adv, ($stable(ptr_reg) && $stable(boost_reg)),
        "ladder state changed without a command")
    `RRDL_ASSERT_IMPL(a_flags_excl, out_valid_reg,
        !(m_data_reg[DUTY_OUTS*DUTY_OUT_W] && m_data_reg[DUTY_OUTS*DUTY_OUT_W + 1]),
        "levels reported both full and zero")
    `RRDL_ASSERT_NEXT(a_dec_skip, (adv && func_reg == FUNC_DEC && at_min && !boost_reg),
        $stable(ptr_reg), "decrease at minimum power moved the pointer")

endmodule
